[hw/rtl/xs1024_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024_pkg
// Shared widths and constants of the xorshift1024* generator.
// ----------------------------------------------------------------------------
package xs1024_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int NUM_WORDS = 16;
    localparam int PTR_W     = $clog2(NUM_WORDS);
    localparam int FRAC_W    = 16;
    localparam int DSUM_W    = FRAC_W + 2;

    // MurmurHash3 64-bit finalizer multipliers
    localparam logic [WORD_W-1:0] FMIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] FMIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    // xorshift64* and xorshift1024* output multipliers
    localparam logic [WORD_W-1:0] XS64_MUL   = 64'd2685821657736338717;
    localparam logic [WORD_W-1:0] XS1024_MUL = 64'd1181783497276652981;

    localparam logic [FRAC_W:0] FRAC_DIV = 17'd65535;

    localparam int FMIX_SH  = 33;
    localparam int XS64_SH1 = 12;
    localparam int XS64_SH2 = 25;
    localparam int XS64_SH3 = 27;
    localparam int GEN_SHB1 = 31;
    localparam int GEN_SHB2 = 11;
    localparam int GEN_SHA  = 30;

    // Operation codes carried on the input side-band
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

endpackage : xs1024_pkg
`default_nettype wire

[hw/rtl/xs1024_mul64.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024_mul64
// Iterative 64x64 multiply, low 64 bits of the product, built from one
// shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module xs1024_mul64 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [xs1024_pkg::WORD_W-1:0] op_a,
    input  wire logic [xs1024_pkg::WORD_W-1:0] op_b,
    output logic                               done,
    output logic [xs1024_pkg::WORD_W-1:0]      product
);

    localparam int HW = xs1024_pkg::HALF_W;
    localparam int WW = xs1024_pkg::WORD_W;

    logic [WW-1:0] a_reg;
    logic [WW-1:0] b_reg;
    logic [WW-1:0] prod_reg;
    logic [WW-1:0] acc_reg;
    logic          run_reg;
    logic [1:0]    step_reg;
    logic          done_reg;

    logic [HW-1:0] m_a;
    logic [HW-1:0] m_b;
    logic [WW-1:0] mul_full;

    // Select the partial product for this step; the high-by-high term
    // falls entirely above bit 63 and is dropped.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                m_a = a_reg[HW-1:0];
                m_b = b_reg[HW-1:0];
            end
            2'd1:
            begin
                m_a = a_reg[HW-1:0];
                m_b = b_reg[WW-1:HW];
            end
            default:
            begin
                m_a = a_reg[WW-1:HW];
                m_b = b_reg[HW-1:0];
            end
        endcase
    end

    assign mul_full = {{HW{1'b0}}, m_a} * {{HW{1'b0}}, m_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == 2'd3);
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (run_reg)
        begin
            prod_reg <= mul_full;
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule : xs1024_mul64
`default_nettype wire

[hw/rtl/xorshift1024star_generator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift1024star_generator_unit
// xorshift1024* pseudo-random generator with MurmurHash3-scrambled seeding.
// ----------------------------------------------------------------------------
// Operation: a next transfer gives one result; a seed transfer keeps the
//   unit busy until all sixteen words are written and gives no result.
// Flow: one item at a time; both kinds use the shared 64-bit
//   multiplier, and a new transfer is taken only in the idle state; a
//   result that still waits downstream holds a next item longer.
// Reset: all sixteen state words read as zero and the pointer is zero.
// ----------------------------------------------------------------------------
module xorshift1024star_generator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] seed
    input  wire logic        s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata    // [63:0] value, [79:64] fraction_numerator
);

    localparam int WW = xs1024_pkg::WORD_W;
    localparam int PW = xs1024_pkg::PTR_W;
    localparam int NW = xs1024_pkg::NUM_WORDS;
    localparam int FW = xs1024_pkg::FRAC_W;
    localparam int DW = xs1024_pkg::DSUM_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AV_SH,
        S_XS_SH1,
        S_XS_SH2,
        S_XS_SH3,
        S_MUL_GO,
        S_MUL_WAIT,
        S_RD_A,
        S_RD_B,
        S_DIG,
        S_FOLD
    } state_t;

    // Which multiplier constant the current product uses
    typedef enum logic [1:0] {
        M_FMIX_A,
        M_FMIX_B,
        M_XS64,
        M_XS1024
    } msel_t;

    // Sequencer registers
    state_t        state_reg,  state_next;
    msel_t         msel_reg,   msel_next;
    logic [WW-1:0] acc_reg,    acc_next;
    logic [1:0]    sub_reg,    sub_next;
    logic          round_reg,  round_next;
    logic [PW-1:0] idx_reg,    idx_next;
    logic [PW-1:0] ptr_reg,    ptr_next;
    logic [NW-1:0] valid_reg,  valid_next;
    logic [DW-1:0] dsum_reg,   dsum_next;
    logic          ovalid_reg, ovalid_next;
    logic [WW-1:0] oval_reg,   oval_next;
    logic [FW-1:0] ofrac_reg,  ofrac_next;

    // State word store, one read port with registered data
    logic [WW-1:0] mem [NW];
    logic [WW-1:0] rd_data_reg;
    logic          rd_ok_reg;
    logic [PW-1:0] rd_addr;
    logic [WW-1:0] rd_word;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    // Shared multiplier
    logic          mul_start;
    logic [WW-1:0] mul_const;
    logic          mul_done;
    logic [WW-1:0] mul_prod;

    // Mixing and fraction datapath
    logic [WW-1:0] b_sh1;
    logic [WW-1:0] b_mix;
    logic [WW-1:0] mixed;
    logic [FW:0]   fold;
    logic [FW-1:0] frac;
    logic          s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A word that was never written since reset reads as zero
    assign rd_word = rd_ok_reg ? rd_data_reg : '0;

    assign b_sh1 = rd_word ^ (rd_word << xs1024_pkg::GEN_SHB1);
    assign b_mix = b_sh1 ^ (b_sh1 >> xs1024_pkg::GEN_SHB2);
    assign mixed = acc_reg ^ b_mix;

    // 2^16 = 1 mod 65535: fold the digit sum once, then one correction
    assign fold = {1'b0, dsum_reg[FW-1:0]} + {{(FW - 1){1'b0}}, dsum_reg[DW-1:FW]};
    assign frac = (fold >= xs1024_pkg::FRAC_DIV) ? FW'(fold - xs1024_pkg::FRAC_DIV)
                                                 : fold[FW-1:0];

    always_comb
    begin
        case (msel_reg)
            M_FMIX_A: mul_const = xs1024_pkg::FMIX_MUL_A;
            M_FMIX_B: mul_const = xs1024_pkg::FMIX_MUL_B;
            M_XS64:   mul_const = xs1024_pkg::XS64_MUL;
            default:  mul_const = xs1024_pkg::XS1024_MUL;
        endcase
    end

    // Read the current word on acceptance, the following word in the next cycle
    assign rd_addr = (state_reg == S_RD_A) ? ptr_reg + PW'(1) : ptr_reg;

    always_comb
    begin
        state_next  = state_reg;
        msel_next   = msel_reg;
        acc_next    = acc_reg;
        sub_next    = sub_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        valid_next  = valid_reg;
        dsum_next   = dsum_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ofrac_next  = ofrac_reg;
        mul_start   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = mul_prod;

        // Drop the result once the downstream side takes it
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_axis_tuser == xs1024_pkg::OP_SEED)
                    begin
                        acc_next   = s_axis_tdata;
                        sub_next   = 2'd0;
                        round_next = 1'b0;
                        state_next = S_AV_SH;
                    end
                    else
                    begin
                        state_next = S_RD_A;
                    end
                end
            end

            // Finalizer, two passes: shift-xor, multiply A, shift-xor, multiply B, shift-xor
            S_AV_SH:
            begin
                acc_next = acc_reg ^ (acc_reg >> xs1024_pkg::FMIX_SH);
                case (sub_reg)
                    2'd0:
                    begin
                        msel_next  = M_FMIX_A;
                        state_next = S_MUL_GO;
                    end
                    2'd1:
                    begin
                        msel_next  = M_FMIX_B;
                        state_next = S_MUL_GO;
                    end
                    default:
                    begin
                        if (!round_reg)
                        begin
                            round_next = 1'b1;
                            sub_next   = 2'd0;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_XS_SH1;
                        end
                    end
                endcase
            end

            S_XS_SH1:
            begin
                acc_next   = acc_reg ^ (acc_reg >> xs1024_pkg::XS64_SH1);
                state_next = S_XS_SH2;
            end

            S_XS_SH2:
            begin
                acc_next   = acc_reg ^ (acc_reg << xs1024_pkg::XS64_SH2);
                state_next = S_XS_SH3;
            end

            S_XS_SH3:
            begin
                acc_next   = acc_reg ^ (acc_reg >> xs1024_pkg::XS64_SH3);
                msel_next  = M_XS64;
                state_next = S_MUL_GO;
            end

            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
            end

            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_prod;
                    case (msel_reg)
                        M_FMIX_A, M_FMIX_B:
                        begin
                            sub_next   = sub_reg + 2'd1;
                            state_next = S_AV_SH;
                        end
                        M_XS64:
                        begin
                            // Store the running value into the next seed word
                            wr_en               = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            idx_next            = idx_reg + PW'(1);
                            state_next          = (idx_reg == PW'(NW - 1)) ? S_IDLE
                                                                           : S_XS_SH1;
                        end
                        default:
                        begin
                            state_next = S_DIG;
                        end
                    endcase
                end
            end

            // Word at the old pointer is here; advance the pointer
            S_RD_A:
            begin
                acc_next   = rd_word ^ (rd_word >> xs1024_pkg::GEN_SHA);
                ptr_next   = ptr_reg + PW'(1);
                state_next = S_RD_B;
            end

            // Word at the new pointer is here; mix and write back
            S_RD_B:
            begin
                wr_en               = 1'b1;
                wr_addr             = ptr_reg;
                wr_data             = mixed;
                valid_next[ptr_reg] = 1'b1;
                acc_next            = mixed;
                msel_next           = M_XS1024;
                state_next          = S_MUL_GO;
            end

            S_DIG:
            begin
                dsum_next = DW'(acc_reg[15:0]) + DW'(acc_reg[31:16])
                          + DW'(acc_reg[47:32]) + DW'(acc_reg[63:48]);
                state_next = S_FOLD;
            end

            // Hold here while an earlier result still waits downstream
            S_FOLD:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = acc_reg;
                    ofrac_next  = frac;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            msel_reg   <= M_FMIX_A;
            sub_reg    <= 2'd0;
            round_reg  <= 1'b0;
            idx_reg    <= '0;
            ptr_reg    <= '0;
            valid_reg  <= '0;
            ovalid_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            msel_reg   <= msel_next;
            sub_reg    <= sub_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            ptr_reg    <= ptr_next;
            valid_reg  <= valid_next;
            ovalid_reg <= ovalid_next;
            rd_ok_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        dsum_reg  <= dsum_next;
        oval_reg  <= oval_next;
        ofrac_reg <= ofrac_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    xs1024_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (acc_reg),
        .op_b    (mul_const),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {ofrac_reg, oval_reg};

endmodule : xorshift1024star_generator_unit
`default_nettype wire

[hw/rtl/xs1024_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024_checker
// Port-level checks of the xorshift1024* generator, bound to the top level.
// ----------------------------------------------------------------------------
module xs1024_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Fraction numerator is a residue mod 65535
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:64] != 16'hffff)
        else $error("fraction numerator out of range");

    // One item at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // A seed transfer never raises a result by itself
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (s_axis_tuser == xs1024_pkg::OP_SEED) && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("seed produced a result");

endmodule : xs1024_checker

bind xorshift1024star_generator_unit xs1024_checker u_xs1024_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the xorshift1024* generator unit. Drives seed and
// next transfers over the input stream with random gaps, stalls the output
// stream at random, and compares every result against a cycle-free software
// predictor of the sixteen-word state and rotating pointer.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WW = xs1024_pkg::WORD_W;
    localparam int FW = xs1024_pkg::FRAC_W;
    localparam int NW = xs1024_pkg::NUM_WORDS;
    localparam int PW = xs1024_pkg::PTR_W;

    // Result layout on m_axis_tdata, lowest field last in the packed order
    typedef struct packed {
        logic [FW-1:0] fraction_numerator;
        logic [WW-1:0] value;
    } gen_result_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // [63:0] seed
    logic        s_axis_tuser  = 1'b0; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // [63:0] value, [79:64] fraction_numerator

    // Predictor state: mirrors the unit's word store and pointer
    logic [WW-1:0] model_words [NW];
    logic [PW-1:0] model_ptr;

    // Results still owed by the unit, oldest first
    gen_result_t expected_numbers [$];

    int  mismatch_count = 0;
    // When set, neither side inserts gaps or stalls
    bit  no_idle        = 1'b0;

    xorshift1024star_generator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One pass of the 64-bit MurmurHash3 finalizer
    function automatic logic [WW-1:0] fmix64(input logic [WW-1:0] v);
        v = v ^ (v >> xs1024_pkg::FMIX_SH);
        v = v * xs1024_pkg::FMIX_MUL_A;
        v = v ^ (v >> xs1024_pkg::FMIX_SH);
        v = v * xs1024_pkg::FMIX_MUL_B;
        v = v ^ (v >> xs1024_pkg::FMIX_SH);
        return v;
    endfunction

    // One xorshift64* step, used only while filling the word store
    function automatic logic [WW-1:0] xs64_advance(input logic [WW-1:0] v);
        v = v ^ (v >> xs1024_pkg::XS64_SH1);
        v = v ^ (v << xs1024_pkg::XS64_SH2);
        v = v ^ (v >> xs1024_pkg::XS64_SH3);
        return v * xs1024_pkg::XS64_MUL;
    endfunction

    // Refill all sixteen words from a seed; the pointer keeps its value
    function automatic void load_seed_state(input logic [WW-1:0] seed_word);
        logic [WW-1:0] v;
        v = fmix64(fmix64(seed_word));
        for (int i = 0; i < NW; i++)
        begin
            v = xs64_advance(v);
            model_words[i] = v;
        end
    endfunction

    // Advance the pointer, mix the two words and return the scaled product
    function automatic gen_result_t next_random();
        logic [WW-1:0] a;
        logic [WW-1:0] b;
        logic [WW-1:0] mixed;
        logic [WW-1:0] prod;
        gen_result_t   r;
        a         = model_words[model_ptr];
        model_ptr = model_ptr + PW'(1);     // wraps modulo 16
        b         = model_words[model_ptr];
        b         = b ^ (b << xs1024_pkg::GEN_SHB1);
        b         = b ^ (b >> xs1024_pkg::GEN_SHB2);
        a         = a ^ (a >> xs1024_pkg::GEN_SHA);
        mixed     = a ^ b;
        model_words[model_ptr] = mixed;
        prod      = mixed * xs1024_pkg::XS1024_MUL;     // modulo 2^64
        r.value              = prod;
        r.fraction_numerator = FW'(prod % xs1024_pkg::FRAC_DIV);
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < NW; i++)
            model_words[i] = '0;
        model_ptr = '0;
    end

    // ------------------------------------------------------------------
    // Output side: random backpressure and result checking
    // ------------------------------------------------------------------

    // Stall the result stream at random, with a chance of about 23 in a hundred
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 23);

    // Compare every result transfer with the oldest outstanding prediction;
    // values are sampled before this edge's updates take effect
    always @(posedge clk)
    begin : check_results
        gen_result_t got;
        gen_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_numbers.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: result %h arrived with nothing outstanding",
                             $realtime, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (got.value !== want.value ||
                    got.fraction_numerator !== want.fraction_numerator)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: value exp %h got %h, fraction exp %h got %h",
                                 $realtime, want.value, got.value,
                                 want.fraction_numerator, got.fraction_numerator);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item, holding it until the unit takes it, then update the
    // predictor. Valid stays high afterwards so back-to-back items need no
    // second assignment in the same step; callers that pause must drop it.
    task automatic send_item(input logic op, input logic [WW-1:0] seed_word);
        while (!no_idle && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= seed_word;
        do @(posedge clk); while (!s_axis_tready);
        if (op == xs1024_pkg::OP_SEED)
            load_seed_state(seed_word);
        else
            expected_numbers.push_back(next_random());
    endtask

    // Drop valid and hold off until every owed result has been taken
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_numbers.size() != 0);
    endtask

    // Random 64-bit seed, sometimes a single set bit
    function automatic logic [WW-1:0] random_seed();
        if ($urandom_range(7) == 0)
            return 64'd1 << $urandom_range(WW - 1);
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Next items on the reset state: all zero, pointer wraps past 15
    task automatic test_unseeded_state();
        for (int n = 0; n < NW + 1; n++)
            send_item(xs1024_pkg::OP_NEXT, {$urandom, $urandom});
    endtask

    // Seed extremes: all ones, zero (scrambles to an all-zero store), top bit
    task automatic test_seed_extremes();
        send_item(xs1024_pkg::OP_SEED, {WW{1'b1}});
        send_item(xs1024_pkg::OP_NEXT, '0);
        send_item(xs1024_pkg::OP_SEED, '0);
        send_item(xs1024_pkg::OP_NEXT, {WW{1'b1}});
        send_item(xs1024_pkg::OP_SEED, 64'h8000_0000_0000_0000);
        send_item(xs1024_pkg::OP_NEXT, '0);
    endtask

    // Mostly next items with a reseed now and then; pause for a full drain
    // every few hundred items
    task automatic test_random_mix();
        logic op;
        for (int n = 0; n < 1200; n++)
        begin
            op = ($urandom_range(9) == 0) ? xs1024_pkg::OP_SEED : xs1024_pkg::OP_NEXT;
            send_item(op, random_seed());
            if (n % 300 == 299)
                wait_for_results();
        end
    endtask

    // Next items with rarer reseeds, both sides running flat out
    task automatic test_back_to_back();
        logic op;
        no_idle = 1'b1;
        for (int n = 0; n < 400; n++)
        begin
            op = ($urandom_range(19) == 0) ? xs1024_pkg::OP_SEED : xs1024_pkg::OP_NEXT;
            send_item(op, random_seed());
        end
        wait_for_results();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unseeded_state();
        test_seed_extremes();
        test_random_mix();
        test_back_to_back();

        // Drain, then let a trailing seed walk finish
        wait_for_results();
        repeat (200) @(posedge clk);

        if (expected_numbers.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
